### rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// shared widths, codes and request type for the bounded deque
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int CMD_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;
  localparam int M_PAD_W   = M_TDATA_W - VALUE_W - STATUS_W;

  // command codes as they arrive on the bus
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FIRST_N    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LAST_N     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_ALL        = 4'd8;

  // internal operation codes after classification
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_PUSH_FRONT = 4'd1;
  localparam op_t OP_PUSH_BACK  = 4'd2;
  localparam op_t OP_POP_FRONT  = 4'd3;
  localparam op_t OP_POP_BACK   = 4'd4;
  localparam op_t OP_DELETE     = 4'd5;
  localparam op_t OP_CLEAR      = 4'd6;
  localparam op_t OP_FIRST_N    = 4'd7;
  localparam op_t OP_LAST_N     = 4'd8;
  localparam op_t OP_ALL        = 4'd9;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } req_t;

endpackage

### rtl/bdq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_front
// accepts requests and classifies the command into an internal operation
// ----------------------------------------------------------------------------
module bdq_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bdq_pkg::CMD_W-1:0]    command,
  input  logic [bdq_pkg::VALUE_W-1:0]  value,
  input  logic [bdq_pkg::COUNT_W-1:0]  count,
  output logic                         req_valid,
  input  logic                         req_ready,
  output bdq_pkg::req_t                req
);
  import bdq_pkg::*;

  logic vld;
  op_t  op_dec;

  always_comb begin
    case (command)
      CMD_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      CMD_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      CMD_POP_FRONT:  op_dec = OP_POP_FRONT;
      CMD_POP_BACK:   op_dec = OP_POP_BACK;
      CMD_DELETE:     op_dec = OP_DELETE;
      CMD_CLEAR:      op_dec = OP_CLEAR;
      CMD_FIRST_N:    op_dec = OP_FIRST_N;
      CMD_LAST_N:     op_dec = OP_LAST_N;
      CMD_ALL:        op_dec = OP_ALL;
      default:        op_dec = OP_NOP;
    endcase
  end

  assign in_ready  = !vld || req_ready;
  assign req_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.op    <= op_dec;
      req.value <= value;
      req.count <= count;
    end
  end

endmodule

### rtl/bdq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_fifo
// short request queue that decouples the front and back parts
// ----------------------------------------------------------------------------
module bdq_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bdq_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output bdq_pkg::req_t out_req
);
  import bdq_pkg::*;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ready  = (fill != FULL_CNT);
  assign out_valid = (fill != '0);
  assign out_req   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_req;
    end
  end

endmodule

### rtl/bdq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_back
// carries out deque operations on the ring store and drives the results
// ----------------------------------------------------------------------------
module bdq_back #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bdq_pkg::req_t                 req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [bdq_pkg::VALUE_W-1:0]   res_entry,
  output logic                          res_has,
  output logic [bdq_pkg::STATUS_W-1:0]  res_status,
  output logic                          res_last
);
  import bdq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = OCC_W + 1;
  localparam int CMP_W = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [OCC_W-1:0] CAP_OCC  = OCC_W'(CAPACITY);
  localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACK    = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_STREAM = 3'd4;

  // ring slot of a position counted from the front
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [OCC_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(pos);
    if (sum >= CAP_SUM) begin
      sum = sum - CAP_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata;

  logic [2:0]          state, state_next;
  logic [IDX_W-1:0]    front_idx, front_next;
  logic [OCC_W-1:0]    occ, occ_next;
  logic [OCC_W-1:0]    pos, pos_next;
  logic [OCC_W-1:0]    stop, stop_next;
  logic [VALUE_W-1:0]  value_r, value_next;
  logic [STATUS_W-1:0] ack_status, ack_status_next;
  logic                ack_has, ack_has_next;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [VALUE_W-1:0]  wr_data;

  logic                out_vld;
  logic                out_free;
  logic                out_load;
  logic [VALUE_W-1:0]  ld_entry;
  logic                ld_has;
  logic [STATUS_W-1:0] ld_status;
  logic                ld_last;

  logic [OCC_W-1:0]    pos_inc;
  logic [OCC_W-1:0]    pos_inc2;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CMP_W-1:0]    occ_ext;
  logic [OCC_W-1:0]    n_sel;
  logic [OCC_W-1:0]    start;
  logic                is_full;
  logic                is_empty;

  assign out_free  = !out_vld || res_ready;
  assign req_ready = (state == S_IDLE);
  assign pos_inc   = pos + OCC_W'(1);
  assign pos_inc2  = pos + OCC_W'(2);
  assign cnt_ext   = CMP_W'(req.count);
  assign occ_ext   = CMP_W'(occ);
  assign is_full   = (occ == CAP_OCC);
  assign is_empty  = (occ == '0);

  always_comb begin
    if (req.op == OP_ALL) begin
      n_sel = occ;
    end else if (cnt_ext < occ_ext) begin
      n_sel = cnt_ext[OCC_W-1:0];
    end else begin
      n_sel = occ;
    end
    start = (req.op == OP_LAST_N) ? occ - n_sel : '0;
  end

  always_comb begin
    state_next      = state;
    front_next      = front_idx;
    occ_next        = occ;
    pos_next        = pos;
    stop_next       = stop;
    value_next      = value_r;
    ack_status_next = ack_status;
    ack_has_next    = ack_has;
    rd_en           = 1'b0;
    rd_addr         = slot_of(front_idx, pos);
    wr_en           = 1'b0;
    wr_addr         = slot_of(front_idx, pos);
    wr_data         = req.value;
    out_load        = 1'b0;
    ld_entry        = '0;
    ld_has          = 1'b0;
    ld_status       = ST_OK;
    ld_last         = 1'b1;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ack_has_next    = 1'b0;
          ack_status_next = ST_OK;
          value_next      = req.value;
          state_next      = S_ACK;
          case (req.op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                ack_status_next = ST_FULL;
              end else begin
                front_next = (front_idx == '0) ? LAST_IDX : front_idx - IDX_W'(1);
                wr_en      = 1'b1;
                wr_addr    = front_next;
                occ_next   = occ + OCC_W'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                ack_status_next = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = slot_of(front_idx, occ);
                occ_next = occ + OCC_W'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                ack_status_next = ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = front_idx;
                front_next   = (front_idx == LAST_IDX) ? '0 : front_idx + IDX_W'(1);
                occ_next     = occ - OCC_W'(1);
                ack_has_next = 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                ack_status_next = ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = slot_of(front_idx, occ - OCC_W'(1));
                occ_next     = occ - OCC_W'(1);
                ack_has_next = 1'b1;
              end
            end
            OP_DELETE: begin
              if (is_empty) begin
                ack_status_next = ST_NOT_FOUND;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = front_idx;
                pos_next   = '0;
                state_next = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              front_next = '0;
              occ_next   = '0;
            end
            OP_FIRST_N, OP_LAST_N, OP_ALL: begin
              if (n_sel != '0) begin
                rd_en      = 1'b1;
                rd_addr    = slot_of(front_idx, start);
                pos_next   = start;
                stop_next  = start + n_sel;
                state_next = S_STREAM;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_entry   = ack_has ? rdata : '0;
          ld_has     = ack_has;
          ld_status  = ack_status;
          state_next = S_IDLE;
        end
      end

      // rdata holds the entry at pos
      S_SEARCH: begin
        if (rdata == value_r) begin
          if (pos_inc == occ) begin
            occ_next   = occ - OCC_W'(1);
            state_next = S_ACK;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = slot_of(front_idx, pos_inc);
            state_next = S_SHIFT;
          end
        end else if (pos_inc == occ) begin
          ack_status_next = ST_NOT_FOUND;
          state_next      = S_ACK;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = slot_of(front_idx, pos_inc);
          pos_next = pos_inc;
        end
      end

      // rdata holds the entry at pos + 1, moved down into pos
      S_SHIFT: begin
        wr_en    = 1'b1;
        wr_addr  = slot_of(front_idx, pos);
        wr_data  = rdata;
        pos_next = pos_inc;
        if (pos_inc2 == occ) begin
          occ_next   = occ - OCC_W'(1);
          state_next = S_ACK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_of(front_idx, pos_inc2);
        end
      end

      S_STREAM: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_entry = rdata;
          ld_has   = 1'b1;
          ld_last  = (pos_inc == stop);
          if (pos_inc == stop) begin
            state_next = S_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(front_idx, pos_inc);
            pos_next = pos_inc;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_idx <= '0;
      occ       <= '0;
    end else begin
      state     <= state_next;
      front_idx <= front_next;
      occ       <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    stop       <= stop_next;
    value_r    <= value_next;
    ack_status <= ack_status_next;
    ack_has    <= ack_has_next;
  end

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (res_ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_entry  <= ld_entry;
      res_has    <= ld_has;
      res_status <= ld_status;
      res_last   <= ld_last;
    end
  end

  assign res_valid = out_vld;

endmodule

### rtl/bounded_deque_with_value_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete
// bounded double-ended queue of signed 32-bit values with delete by value
// ----------------------------------------------------------------------------
// Each request carries a command: push front or back, pop front or back,
// delete the first entry equal to a value (closing the gap), clear, or stream
// the first n, the last n or all entries front to back. Every request yields
// one or more results, the final one flagged by tlast; a push when full, a pop
// when empty or a missing delete value gives one result with a nonzero status.
// A front stage registers and classifies requests into a two-deep request
// queue, so requests keep flowing in while the back part is busy. The back
// part works on one request at a time against a ring store of CAPACITY
// entries with one write and one registered read per cycle. A stream sends
// one entry per cycle while the result side keeps up. A delete searches
// from the front for the first equal entry, then moves each later entry
// down by one, then gives its result; a delete whose value is missing
// searches the whole occupancy. The result sits in an output register; a
// stalled result side holds the back part, and the request side blocks once
// the front stage and the request queue are full.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // command [3:0], value [35:4], count [41:36], zero pad above
  input  logic [bdq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // result side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // entry [31:0], status [33:32], zero pad above
  output logic [bdq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // has_entry [0]
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import bdq_pkg::*;

  // request field unpacking
  logic [CMD_W-1:0]    command;
  logic [VALUE_W-1:0]  value;
  logic [COUNT_W-1:0]  count;

  assign command = s_axis_tdata[CMD_W-1:0];
  assign value   = s_axis_tdata[CMD_W +: VALUE_W];
  assign count   = s_axis_tdata[CMD_W + VALUE_W +: COUNT_W];

  // front to queue
  req_t front_req;
  logic front_valid;
  logic front_ready;

  // queue to back
  req_t back_req;
  logic back_valid;
  logic back_ready;

  // results from the back part
  logic [VALUE_W-1:0]  entry;
  logic                has_entry;
  logic [STATUS_W-1:0] status;
  logic                last;

  bdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .command   (command),
    .value     (value),
    .count     (count),
    .req_valid (front_valid),
    .req_ready (front_ready),
    .req       (front_req)
  );

  // decouples classification from execution
  bdq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_req    (front_req),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_req   (back_req)
  );

  bdq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (back_valid),
    .req_ready  (back_ready),
    .req        (back_req),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_entry  (entry),
    .res_has    (has_entry),
    .res_status (status),
    .res_last   (last)
  );

  // result packing
  assign m_axis_tdata = {{M_PAD_W{1'b0}}, status, entry};
  assign m_axis_tuser = has_entry;
  assign m_axis_tlast = last;

endmodule

### tb/sv/bounded_deque_with_value_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete_tb
// self-checking bench for the bounded deque with delete by value
// ----------------------------------------------------------------------------
// Requests come from a pending list built up front. A short directed opening
// covers empty refusals, value extremes, saturating streams, duplicate deletes
// and unknown commands. A fill into the full refusal and random segments
// follow: push runs, drains often past empty, and mixed traffic whose deletes
// mostly aim at pushed values. A clocked driver sends the requests in bursts
// with gaps. On every accepted request it runs a behavioral deque and queues
// the results it predicts. A clocked monitor, with a stalling receiver of its
// own, checks each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete_tb;
  import bdq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 4'd15;
  localparam int               DEQ_CAP       = CAPACITY_DEF;
  localparam int               S_PAD_W       = S_TDATA_W - CMD_W - VALUE_W - COUNT_W;
  // worst back-end time of one request (delete with a full walk) plus margin
  localparam int               DRAIN_CYCLES  = 2 * DEQ_CAP + 40;

  // one request as queued for the driver
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               drain_first;  // hold off until every result is back
  } deque_req_t;

  // one result as expected on the master side
  typedef struct packed {
    logic [VALUE_W-1:0]  entry;
    logic                has_entry;
    logic [STATUS_W-1:0] status;
    logic                last;
  } deque_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  deque_req_t    pending_reqs[$];
  deque_result_t expected_results[$];
  logic [VALUE_W-1:0] pushed_values[$];  // candidates for deletes that hit
  deque_req_t    req_in_flight;
  int            mismatch_count = 0;

  // behavioral copy of the ring store
  logic [VALUE_W-1:0] deque_store[DEQ_CAP];
  int                 deque_head = 0;
  int                 deque_fill = 0;

  always #10 clk = ~clk;

  bounded_deque_with_value_delete i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  function automatic void expect_result(logic [VALUE_W-1:0] entry, logic has_entry,
                                        logic [STATUS_W-1:0] status, logic last);
    deque_result_t r;
    r.entry     = entry;
    r.has_entry = has_entry;
    r.status    = status;
    r.last      = last;
    expected_results.push_back(r);
  endfunction

  // stream n entries front to back, starting at position first_pos
  function automatic void expect_stream(int first_pos, int n);
    if (n == 0) begin
      expect_result('0, 1'b0, ST_OK, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        expect_result(deque_store[(deque_head + first_pos + i) % DEQ_CAP], 1'b1, ST_OK,
                      i == n - 1);
      end
    end
  endfunction

  function automatic void apply_deque_command(deque_req_t req);
    int n;
    int pos;
    int slot;
    n = (int'(req.count) < deque_fill) ? int'(req.count) : deque_fill;
    case (req.cmd)
      CMD_PUSH_FRONT: begin
        if (deque_fill >= DEQ_CAP) begin
          expect_result('0, 1'b0, ST_FULL, 1'b1);
        end else begin
          deque_head = (deque_head + DEQ_CAP - 1) % DEQ_CAP;
          deque_store[deque_head] = req.value;
          deque_fill++;
          expect_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      CMD_PUSH_BACK: begin
        if (deque_fill >= DEQ_CAP) begin
          expect_result('0, 1'b0, ST_FULL, 1'b1);
        end else begin
          deque_store[(deque_head + deque_fill) % DEQ_CAP] = req.value;
          deque_fill++;
          expect_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      CMD_POP_FRONT: begin
        if (deque_fill == 0) begin
          expect_result('0, 1'b0, ST_EMPTY, 1'b1);
        end else begin
          expect_result(deque_store[deque_head], 1'b1, ST_OK, 1'b1);
          deque_head = (deque_head + 1) % DEQ_CAP;
          deque_fill--;
        end
      end
      CMD_POP_BACK: begin
        if (deque_fill == 0) begin
          expect_result('0, 1'b0, ST_EMPTY, 1'b1);
        end else begin
          expect_result(deque_store[(deque_head + deque_fill - 1) % DEQ_CAP], 1'b1, ST_OK,
                        1'b1);
          deque_fill--;
        end
      end
      CMD_DELETE: begin
        // first match from the front, then shift the tail down by one
        pos = 0;
        while (pos < deque_fill && deque_store[(deque_head + pos) % DEQ_CAP] != req.value)
          pos++;
        if (pos >= deque_fill) begin
          expect_result('0, 1'b0, ST_NOT_FOUND, 1'b1);
        end else begin
          for (int i = pos; i + 1 < deque_fill; i++) begin
            slot = (deque_head + i) % DEQ_CAP;
            deque_store[slot] = deque_store[(slot + 1) % DEQ_CAP];
          end
          deque_fill--;
          expect_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      CMD_CLEAR: begin
        deque_head = 0;
        deque_fill = 0;
        expect_result('0, 1'b0, ST_OK, 1'b1);
      end
      CMD_FIRST_N: expect_stream(0, n);
      CMD_LAST_N:  expect_stream(deque_fill - n, n);
      CMD_ALL:     expect_stream(0, deque_fill);
      default:     expect_result('0, 1'b0, ST_OK, 1'b1);  // unknown code, no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  function automatic void add_req(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                  logic [COUNT_W-1:0] count, logic drain_first);
    deque_req_t r;
    r.cmd         = cmd;
    r.value       = value;
    r.count       = count;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)
      pushed_values.push_back(value);
  endfunction

  // small values repeat often so duplicates and first-match deletes occur
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = $urandom_range(0, 6);
        v = v - 3;
      end
      4:       v = 32'h7fff_ffff;
      5:       v = 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    return ($urandom_range(0, 4) == 0) ? COUNT_W'(DEQ_CAP) : COUNT_W'($urandom_range(0, 31));
  endfunction

  // deletes mostly aim at a value that was pushed at some point
  function automatic logic [VALUE_W-1:0] pick_delete_value();
    if (pushed_values.size() != 0 && $urandom_range(0, 3) != 0)
      return pushed_values[$urandom_range(0, pushed_values.size() - 1)];
    return pick_value();
  endfunction

  function automatic void add_random_req();
    logic drain;
    int   roll;
    drain = ($urandom_range(0, 29) == 0);
    roll  = $urandom_range(0, 99);
    if (roll < 18)
      add_req(CMD_PUSH_FRONT, pick_value(), pick_count(), drain);
    else if (roll < 36)
      add_req(CMD_PUSH_BACK, pick_value(), pick_count(), drain);
    else if (roll < 46)
      add_req(CMD_POP_FRONT, pick_value(), pick_count(), drain);
    else if (roll < 56)
      add_req(CMD_POP_BACK, pick_value(), pick_count(), drain);
    else if (roll < 71)
      add_req(CMD_DELETE, pick_delete_value(), pick_count(), drain);
    else if (roll < 80)
      add_req(CMD_FIRST_N, pick_value(), pick_count(), drain);
    else if (roll < 89)
      add_req(CMD_LAST_N, pick_value(), pick_count(), drain);
    else if (roll < 95)
      add_req(CMD_ALL, pick_value(), pick_count(), drain);
    else if (roll < 97)
      add_req(CMD_CLEAR, pick_value(), pick_count(), drain);
    else
      add_req(CMD_ALL + 4'd1 + CMD_W'($urandom_range(0, CMD_UNDEFINED - CMD_ALL - 1)),
              pick_value(), pick_count(), drain);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of requests with random gaps between them
  // ---------------------------------------------------------------------------
  int tx_burst_left = 1;
  int tx_gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // a request accepted at this edge updates the prediction right away
      if (s_axis_tvalid && s_axis_tready)
        apply_deque_command(req_in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain_first && expected_results.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          req_in_flight = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{S_PAD_W{1'b0}}, req_in_flight.count, req_in_flight.value,
                            req_in_flight.cmd};
          tx_burst_left--;
          if (tx_burst_left <= 0) begin
            tx_burst_left = $urandom_range(1, 24);
            // some bursts run back to back with no gap at all
            tx_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: phases of always ready, random stalls and a sparse pattern
  // ---------------------------------------------------------------------------
  int rx_mode       = 0;
  int rx_phase_left = 0;
  int rx_tick       = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       = $urandom_range(0, 2);
        rx_phase_left = $urandom_range(10, 120);
      end
      rx_phase_left--;
      rx_tick++;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (rx_tick % 6) == 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.entry     = m_axis_tdata[VALUE_W-1:0];
      got.status    = m_axis_tdata[VALUE_W +: STATUS_W];
      got.has_entry = m_axis_tuser;
      got.last      = m_axis_tlast;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result entry %h has_entry %0d status %0d last %0d",
                   $time, got.entry, got.has_entry, got.status, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch, expected entry %h has_entry %0d status %0d last %0d,",
                      " got entry %h has_entry %0d status %0d last %0d"},
                     $time, want.entry, want.has_entry, want.status, want.last,
                     got.entry, got.has_entry, got.status, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int budget;
    int seg_len;

    // directed opening: refusals on empty, extremes, streams, deletes
    add_req(CMD_POP_FRONT, '0, '0, 1'b0);
    add_req(CMD_POP_BACK, '0, '0, 1'b0);
    add_req(CMD_DELETE, 32'd5, '0, 1'b0);           // not found on empty
    add_req(CMD_FIRST_N, '0, COUNT_W'(DEQ_CAP), 1'b0);  // nothing to stream
    add_req(CMD_ALL, '0, '0, 1'b0);
    add_req(CMD_PUSH_FRONT, 32'h7fff_ffff, '0, 1'b0);   // head wraps below zero
    add_req(CMD_PUSH_BACK, 32'h8000_0000, '0, 1'b0);
    add_req(CMD_PUSH_FRONT, 32'h0000_0000, '0, 1'b0);
    add_req(CMD_PUSH_BACK, 32'hffff_ffff, '0, 1'b0);
    add_req(CMD_PUSH_BACK, 32'h8000_0000, '0, 1'b0);    // duplicate value
    add_req(CMD_ALL, '0, '0, 1'b0);
    add_req(CMD_FIRST_N, '0, '0, 1'b0);                 // count zero
    add_req(CMD_FIRST_N, '0, 6'd2, 1'b0);
    add_req(CMD_LAST_N, '0, COUNT_W'(DEQ_CAP), 1'b0);   // saturates at occupancy
    add_req(CMD_LAST_N, '0, 6'd1, 1'b0);
    add_req(CMD_DELETE, 32'h8000_0000, '0, 1'b0);       // removes the first copy only
    add_req(CMD_ALL, '0, '0, 1'b0);
    add_req(CMD_DELETE, 32'd12345, '0, 1'b0);
    add_req(CMD_POP_FRONT, '0, '0, 1'b0);
    add_req(CMD_POP_BACK, '0, '0, 1'b0);
    add_req(CMD_UNDEFINED, 32'hdead_beef, 6'h3f, 1'b0);  // ignored code
    add_req(CMD_ALL, '0, '0, 1'b1);                     // sent on an idle block
    add_req(CMD_CLEAR, '0, '0, 1'b0);
    add_req(CMD_ALL, '0, '0, 1'b0);

    // random part, starting from a fill that runs into the full refusal
    add_req(CMD_CLEAR, '0, '0, 1'b1);
    for (int i = 0; i < DEQ_CAP + 3; i++)
      add_req($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value(),
              pick_count(), 1'b0);
    add_req(CMD_ALL, '0, '0, 1'b0);
    budget = pending_reqs.size();
    while (budget < 100) begin
      case ($urandom_range(0, 3))
        0: begin
          // drain, often past empty
          seg_len = $urandom_range(4, DEQ_CAP + 2);
          for (int i = 0; i < seg_len; i++)
            add_req($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value(),
                    pick_count(), 1'b0);
          add_req(CMD_ALL, '0, '0, 1'b0);
          budget += seg_len + 1;
        end
        1: begin
          seg_len = $urandom_range(5, DEQ_CAP + 2);
          for (int i = 0; i < seg_len; i++)
            add_req($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value(),
                    pick_count(), 1'b0);
          budget += seg_len;
        end
        default: begin
          seg_len = $urandom_range(8, 20);
          for (int i = 0; i < seg_len; i++)
            add_random_req();
          budget += seg_len;
        end
      endcase
    end
    add_req(CMD_ALL, '0, '0, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // everything sent, every result back, then a quiet tail for strays
    while (pending_reqs.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("bounded_deque_with_value_delete_tb: done, clean");
    end else begin
      $display("bounded_deque_with_value_delete_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("bounded_deque_with_value_delete_tb: done, errors");
    $finish;
  end

endmodule

### bounded_deque_with_value_delete.f
rtl/bdq_pkg.sv
rtl/bdq_front.sv
rtl/bdq_fifo.sv
rtl/bdq_back.sv
rtl/bounded_deque_with_value_delete.sv
tb/sv/bounded_deque_with_value_delete_tb.sv
